// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the signature matcher checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("assertion failed: expression does not hold");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle consequent does not hold");

`endif

// ===== hdl/esm_pkg.sv =====
// ---------------------------------------------------------------------------
// esm_pkg
// Types, pattern tables and codes for the byte signature matcher.
// ---------------------------------------------------------------------------
package esm_pkg;

    localparam int HIST_DEPTH = 15;
    localparam int PAT_MAX    = HIST_DEPTH + 1;
    localparam int PAT_COUNT  = 17;
    localparam int FLAG_COUNT = 22;

    // run counter saturation points
    localparam int ZERO_SAT   = 32;
    localparam int LETTER_SAT = 24;
    localparam int NOP_SAT    = 16;
    localparam int ZERO_W     = $clog2(ZERO_SAT + 1);
    localparam int LETTER_W   = $clog2(LETTER_SAT + 1);
    localparam int NOP_W      = $clog2(NOP_SAT + 1);

    localparam logic [7:0] BYTE_ZERO   = 8'h00;
    localparam logic [7:0] BYTE_LETTER = 8'h41;
    localparam logic [7:0] BYTE_NOP    = 8'h90;

    // flag bit numbers: patterns are 0..16, run limits follow
    localparam int FL_SMB_TRANS = 0;
    localparam int FL_05_00     = 1;
    localparam int FL_CHAN_NAME = 2;
    localparam int FL_1F_00     = 3;
    localparam int FL_IFACE_ID  = 4;
    localparam int FL_59_000    = 5;
    localparam int FL_PIPE_SEP  = 6;
    localparam int FL_SMB3_HDR  = 7;
    localparam int FL_ALL_ONES  = 8;
    localparam int FL_00100000  = 9;
    localparam int FL_REFL_LDR  = 10;
    localparam int FL_BCN_X64   = 11;
    localparam int FL_BCN_X86   = 12;
    localparam int FL_METSRV    = 13;
    localparam int FL_MZ        = 14;
    localparam int FL_32_000    = 15;
    localparam int FL_51_00     = 16;
    localparam int FL_RUN_Z32   = 17;
    localparam int FL_RUN_Z24   = 18;
    localparam int FL_RUN_A16   = 19;
    localparam int FL_RUN_A24   = 20;
    localparam int FL_RUN_N16   = 21;

    localparam int RUN_A16 = 16;

    typedef logic [7:0] pat_bytes_t [PAT_MAX];

    localparam int PAT_LEN [PAT_COUNT] = '{
        7, 2, 7, 2, 16, 4, 4, 4, 4, 4, 16, 10, 10, 10, 2, 4, 2
    };

    localparam pat_bytes_t PAT_BYTES [PAT_COUNT] = '{
        '{0: 8'h81, 1: 8'hF1, 2: 8'h13, 3: 8'h00, 4: 8'h00, 5: 8'h00, 6: 8'h49,
          default: 8'h00},
        '{0: 8'h05, 1: 8'h00, default: 8'h00},
        // "MS_T120"
        '{0: 8'h4D, 1: 8'h53, 2: 8'h5F, 3: 8'h54, 4: 8'h31, 5: 8'h32, 6: 8'h30,
          default: 8'h00},
        '{0: 8'h1F, 1: 8'h00, default: 8'h00},
        // 16-byte RPC interface id
        '{8'h12, 8'h34, 8'h56, 8'h78, 8'h12, 8'h34, 8'hAB, 8'hCD,
          8'hEF, 8'h00, 8'h01, 8'h23, 8'h45, 8'h67, 8'h89, 8'hAB},
        '{0: 8'h59, 1: 8'h00, 2: 8'h00, 3: 8'h00, default: 8'h00},
        '{0: 8'h5C, 1: 8'h00, 2: 8'h5C, 3: 8'h00, default: 8'h00},
        '{0: 8'hFC, 1: 8'h53, 2: 8'h4D, 3: 8'h42, default: 8'h00},
        '{0: 8'hFF, 1: 8'hFF, 2: 8'hFF, 3: 8'hFF, default: 8'h00},
        '{0: 8'h00, 1: 8'h10, 2: 8'h00, 3: 8'h00, default: 8'h00},
        // "ReflectiveLoader"
        '{8'h52, 8'h65, 8'h66, 8'h6C, 8'h65, 8'h63, 8'h74, 8'h69,
          8'h76, 8'h65, 8'h4C, 8'h6F, 8'h61, 8'h64, 8'h65, 8'h72},
        // "beacon.x64"
        '{0: 8'h62, 1: 8'h65, 2: 8'h61, 3: 8'h63, 4: 8'h6F, 5: 8'h6E, 6: 8'h2E,
          7: 8'h78, 8: 8'h36, 9: 8'h34, default: 8'h00},
        // "beacon.x86"
        '{0: 8'h62, 1: 8'h65, 2: 8'h61, 3: 8'h63, 4: 8'h6F, 5: 8'h6E, 6: 8'h2E,
          7: 8'h78, 8: 8'h38, 9: 8'h36, default: 8'h00},
        // "metsrv.dll"
        '{0: 8'h6D, 1: 8'h65, 2: 8'h74, 3: 8'h73, 4: 8'h72, 5: 8'h76, 6: 8'h2E,
          7: 8'h64, 8: 8'h6C, 9: 8'h6C, default: 8'h00},
        // "MZ"
        '{0: 8'h4D, 1: 8'h5A, default: 8'h00},
        '{0: 8'h32, 1: 8'h00, 2: 8'h00, 3: 8'h00, default: 8'h00},
        '{0: 8'h51, 1: 8'h00, default: 8'h00}
    };

    // protocol kinds
    localparam logic [2:0] KIND_UNKNOWN = 3'd0;
    localparam logic [2:0] KIND_SMB1    = 3'd1;
    localparam logic [2:0] KIND_SMB2    = 3'd2;
    localparam logic [2:0] KIND_RDP     = 3'd3;
    localparam logic [2:0] KIND_HTTP    = 3'd4;

    // rule ids
    localparam logic [2:0] RULE_NONE       = 3'd0;
    localparam logic [2:0] RULE_SMB1_TRANS = 3'd1;
    localparam logic [2:0] RULE_SMB1_PING  = 3'd2;
    localparam logic [2:0] RULE_SMB3_COMP  = 3'd3;
    localparam logic [2:0] RULE_RDP_CHAN   = 3'd4;
    localparam logic [2:0] RULE_SPOOLER    = 3'd5;
    localparam logic [2:0] RULE_STAGER     = 3'd6;

    typedef struct packed {
        logic       matched;
        logic [2:0] rule_id;
    } esm_result_t;

endpackage

// ===== hdl/exploit_signature_matcher.sv =====
// ---------------------------------------------------------------------------
// exploit_signature_matcher
// Byte-stream signature matcher with six fixed rules, one verdict per packet.
// ---------------------------------------------------------------------------
// Payload bytes enter one per cycle while s_ready is high, with no gap between
// packets. Each byte shifts into a 15-stage chain of history cells; the
// current byte and the chain taps are compared against all 17 fixed patterns
// in parallel, three saturating run counters track runs of 00, 41 and 90,
// and sticky seen flags collect hits. The transaction that carries the
// end-of-packet mark yields exactly one result transaction (matched,
// rule_id), chosen by rule priority and gated by s_proto_kind of that last
// byte; all window, counter and flag state clears for the next packet. The
// result shows on m_valid the cycle after the last byte when the output
// register is free, otherwise it waits in the skid until the output drains.
// Results sit in an output register backed by a one-entry skid buffer, so
// s_ready drops only while the skid holds a result that m_ready has not yet
// drained.
// ---------------------------------------------------------------------------
module exploit_signature_matcher
    import esm_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_payload_byte,
    input  logic       s_end_of_packet,
    input  logic [2:0] s_proto_kind,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_matched,
    output logic [2:0] m_rule_id
);

    logic s_fire;
    logic pkt_end;

    assign s_fire  = s_valid && s_ready;
    assign pkt_end = s_fire && s_end_of_packet;

    // ---- history chain: cell 0 holds the most recent prior byte ----
    logic [7:0]            hist     [HIST_DEPTH];
    logic [HIST_DEPTH-1:0] hist_vld;

    genvar c;
    generate
        for (c = 0; c < HIST_DEPTH; c++) begin : g_cell
            if (c == 0) begin : g_head
                esm_cell u_cell (
                    .aclk     (aclk),
                    .aresetn  (aresetn),
                    .shift    (s_fire),
                    .clear    (pkt_end),
                    .din      (s_payload_byte),
                    .din_vld  (1'b1),
                    .dout     (hist[c]),
                    .dout_vld (hist_vld[c])
                );
            end else begin : g_body
                esm_cell u_cell (
                    .aclk     (aclk),
                    .aresetn  (aresetn),
                    .shift    (s_fire),
                    .clear    (pkt_end),
                    .din      (hist[c-1]),
                    .din_vld  (hist_vld[c-1]),
                    .dout     (hist[c]),
                    .dout_vld (hist_vld[c])
                );
            end
        end
    endgenerate

    // ---- pattern compare: tap 0 is the incoming byte, tap k is cell k-1 ----
    logic [PAT_MAX-1:0]   tap_ok [PAT_COUNT];
    logic [PAT_COUNT-1:0] pat_hit;

    genvar p, k;
    generate
        for (p = 0; p < PAT_COUNT; p++) begin : g_pat
            localparam int L = PAT_LEN[p];
            for (k = 0; k < PAT_MAX; k++) begin : g_tap
                if (k == 0) begin : g_cur
                    assign tap_ok[p][k] = (s_payload_byte == PAT_BYTES[p][L-1]);
                end else if (k < L) begin : g_hist
                    assign tap_ok[p][k] = hist_vld[k-1] &&
                                          (hist[k-1] == PAT_BYTES[p][L-1-k]);
                end else begin : g_pad
                    assign tap_ok[p][k] = 1'b1;
                end
            end
            assign pat_hit[p] = &tap_ok[p];
        end
    endgenerate

    // ---- run counters ----
    logic [ZERO_W-1:0]   zero_cnt;
    logic [LETTER_W-1:0] letter_cnt;
    logic [NOP_W-1:0]    nop_cnt;

    esm_run_cnt #(.CntW(ZERO_W), .Sat(ZERO_SAT)) u_zero_cnt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (s_fire),
        .clear    (pkt_end),
        .hit      (s_payload_byte == BYTE_ZERO),
        .cnt_next (zero_cnt)
    );

    esm_run_cnt #(.CntW(LETTER_W), .Sat(LETTER_SAT)) u_letter_cnt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (s_fire),
        .clear    (pkt_end),
        .hit      (s_payload_byte == BYTE_LETTER),
        .cnt_next (letter_cnt)
    );

    esm_run_cnt #(.CntW(NOP_W), .Sat(NOP_SAT)) u_nop_cnt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (s_fire),
        .clear    (pkt_end),
        .hit      (s_payload_byte == BYTE_NOP),
        .cnt_next (nop_cnt)
    );

    // ---- sticky seen flags ----
    logic [FLAG_COUNT-1:0] flags_reg;
    logic [FLAG_COUNT-1:0] flags_next;

    always_comb begin
        flags_next = flags_reg;
        flags_next[PAT_COUNT-1:0] = flags_reg[PAT_COUNT-1:0] | pat_hit;
        if (zero_cnt >= ZERO_W'(ZERO_SAT))     flags_next[FL_RUN_Z32] = 1'b1;
        if (zero_cnt >= ZERO_W'(LETTER_SAT))   flags_next[FL_RUN_Z24] = 1'b1;
        if (letter_cnt >= LETTER_W'(RUN_A16))  flags_next[FL_RUN_A16] = 1'b1;
        if (letter_cnt >= LETTER_W'(LETTER_SAT)) flags_next[FL_RUN_A24] = 1'b1;
        if (nop_cnt >= NOP_W'(NOP_SAT))        flags_next[FL_RUN_N16] = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg <= '0;
        end else if (pkt_end) begin
            flags_reg <= '0;
        end else if (s_fire) begin
            flags_reg <= flags_next;
        end
    end

    // ---- rule priority, gated by kind of the last byte ----
    esm_result_t new_res;
    logic        kind_smb2ish;
    logic        kind_http;

    assign kind_smb2ish = s_proto_kind inside {KIND_UNKNOWN, KIND_SMB2};
    assign kind_http    = s_proto_kind inside {KIND_UNKNOWN, KIND_HTTP};

    always_comb begin
        new_res.rule_id = RULE_NONE;
        if ((s_proto_kind == KIND_SMB1) && (flags_next[FL_SMB_TRANS] ||
                (flags_next[FL_RUN_Z32] && flags_next[FL_05_00]))) begin
            new_res.rule_id = RULE_SMB1_TRANS;
        end else if ((s_proto_kind == KIND_SMB1) && flags_next[FL_32_000] &&
                     flags_next[FL_51_00] && flags_next[FL_RUN_Z24]) begin
            new_res.rule_id = RULE_SMB1_PING;
        end else if (kind_smb2ish && flags_next[FL_SMB3_HDR] &&
                     (flags_next[FL_ALL_ONES] || flags_next[FL_00100000]) &&
                     (flags_next[FL_RUN_A24] || flags_next[FL_RUN_N16])) begin
            new_res.rule_id = RULE_SMB3_COMP;
        end else if ((s_proto_kind == KIND_RDP) && flags_next[FL_CHAN_NAME] &&
                     flags_next[FL_1F_00] && flags_next[FL_RUN_A16]) begin
            new_res.rule_id = RULE_RDP_CHAN;
        end else if (kind_smb2ish && flags_next[FL_IFACE_ID] &&
                     flags_next[FL_59_000] && flags_next[FL_PIPE_SEP]) begin
            new_res.rule_id = RULE_SPOOLER;
        end else if (kind_http &&
                     (flags_next[FL_REFL_LDR] || flags_next[FL_BCN_X64] ||
                      flags_next[FL_BCN_X86] || flags_next[FL_METSRV]) &&
                     (flags_next[FL_MZ] || flags_next[FL_RUN_N16])) begin
            new_res.rule_id = RULE_STAGER;
        end
        new_res.matched = (new_res.rule_id != RULE_NONE);
    end

    // ---- output register with one-entry skid ----
    logic        out_vld_reg;
    esm_result_t out_res_reg;
    logic        skid_vld_reg;
    esm_result_t skid_res_reg;
    logic        out_free;

    assign out_free = !out_vld_reg || m_ready;
    assign s_ready  = !skid_vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_vld_reg) begin
                out_vld_reg  <= 1'b1;
                skid_vld_reg <= 1'b0;
            end else begin
                out_vld_reg <= pkt_end;
            end
        end else if (pkt_end) begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (skid_vld_reg) begin
                out_res_reg <= skid_res_reg;
            end else if (pkt_end) begin
                out_res_reg <= new_res;
            end
        end else if (pkt_end) begin
            skid_res_reg <= new_res;
        end
    end

    assign m_valid   = out_vld_reg;
    assign m_matched = out_res_reg.matched;
    assign m_rule_id = out_res_reg.rule_id;

endmodule

// ===== hdl/esm_cell.sv =====
// ---------------------------------------------------------------------------
// esm_cell
// One history window stage: a byte and its valid bit, shifted to the next
// stage on every accepted byte; the valid bit clears at packet end.
// ---------------------------------------------------------------------------
module esm_cell (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       shift,
    input  logic       clear,
    input  logic [7:0] din,
    input  logic       din_vld,
    output logic [7:0] dout,
    output logic       dout_vld
);

    logic [7:0] byte_reg;
    logic       vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (clear) begin
            vld_reg <= 1'b0;
        end else if (shift) begin
            vld_reg <= din_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift) begin
            byte_reg <= din;
        end
    end

    assign dout     = byte_reg;
    assign dout_vld = vld_reg;

endmodule

// ===== hdl/esm_run_cnt.sv =====
// ---------------------------------------------------------------------------
// esm_run_cnt
// Saturating run-length counter for one byte value.
// ---------------------------------------------------------------------------
module esm_run_cnt #(
    parameter int CntW = 6,
    parameter int Sat  = 32
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            step,
    input  logic            clear,
    input  logic            hit,
    output logic [CntW-1:0] cnt_next
);

    localparam logic [CntW-1:0] SAT_VAL = CntW'(Sat);

    logic [CntW-1:0] cnt_reg;

    always_comb begin
        if (!hit) begin
            cnt_next = '0;
        end else if (cnt_reg >= SAT_VAL) begin
            cnt_next = SAT_VAL;
        end else begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (clear) begin
            cnt_reg <= '0;
        end else if (step) begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== hdl/esm_checker.sv =====
// ---------------------------------------------------------------------------
// esm_checker
// Port-level checks on the signature matcher, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module esm_checker
    import esm_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       s_end_of_packet,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_matched,
    input logic [2:0] m_rule_id
);

    // stalled result holds
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_rule_id) && $stable(m_matched))

    // matched flag agrees with rule id
    `ASSERT_ALWAYS(a_match_code, aclk, aresetn, !m_valid || (m_matched == (m_rule_id != RULE_NONE)))

    // rule id stays within the defined codes
    `ASSERT_ALWAYS(a_rule_range, aclk, aresetn, !m_valid || (m_rule_id <= RULE_STAGER))

    // a mid-packet byte never creates a result on an idle output
    `ASSERT_NEXT(a_no_spurious, aclk, aresetn, s_valid && s_ready && !s_end_of_packet && !m_valid, !m_valid)

endmodule

bind exploit_signature_matcher esm_checker u_esm_checker (.*);
